// ----- rtl/core/gregorian_day_number_converter_defines.svh -----
// Assertion macros for the Gregorian day number converter.
// Taken in by gregorian_day_number_converter.sv; no other dependencies.
`ifndef GREGORIAN_DAY_NUMBER_CONVERTER_DEFINES_SVH
`define GREGORIAN_DAY_NUMBER_CONVERTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDNC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdnc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GDNC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdnc: next-cycle check failed");

`endif

// ----- rtl/core/gdnc_pkg.sv -----
// Constants, reciprocals and month tables for the Gregorian day number converter.
// No dependencies.
`timescale 1ns / 1ps

package gdnc_pkg;

   localparam int YEAR_W      = 16;
   localparam int MONTH_IN_W  = 6;
   localparam int DAY_IN_W    = 6;
   localparam int SDN_W       = 23;
   localparam int MONTH_OUT_W = 4;
   localparam int DAY_OUT_W   = 5;

   localparam int OFFSET_DAYS   = 32045;
   localparam int FIVE_MONTHS   = 153;
   localparam int FOUR_YEARS    = 1461;
   localparam int FOUR_CENTS    = 146097;
   localparam int EPOCH_YEAR    = 4800;
   localparam int EPOCH_YEAR_BC = 4801;
   localparam int FIRST_YEAR    = 4714;
   localparam int CENTURY       = 100;
   localparam int MAX_DAYNUM    = (1 << SDN_W) - 1;

   // earliest accepted date: 25 Nov 4714 BC
   localparam logic signed [YEAR_W-1:0] EARLIEST_YEAR = YEAR_W'(-FIRST_YEAR);
   localparam int FIRST_MONTH_BC = 11;
   localparam int FIRST_DAY_BC   = 25;

   localparam int FEBRUARY       = 2;
   localparam int MARCH          = 3;
   localparam int DECEMBER       = 12;
   localparam int MONTHS_TO_JAN  = 9;   // March-based month index to Jan/Feb
   localparam int FIRST_NEXT_YR  = 10;  // March-based index of January
   localparam int MAX_MDAY       = 31;

   // (4*(sdn+OFFSET)-1) bias
   localparam int T_BIAS = 4 * OFFSET_DAYS - 1;

   // exact floor division by reciprocal multiply: ceil(2^S/D), S = N + ceil(log2 D)
   localparam int     CENT_SHIFT = 23;  // 16-bit dividend
   localparam longint CENT_RECIP = ((longint'(1) << CENT_SHIFT) + CENTURY - 1) / CENTURY;
   localparam int     FC_SHIFT   = 44;  // 26-bit dividend
   localparam longint FC_RECIP   = ((longint'(1) << FC_SHIFT) + FOUR_CENTS - 1) / FOUR_CENTS;
   localparam int     FY_SHIFT   = 29;  // 18-bit dividend
   localparam longint FY_RECIP   = ((longint'(1) << FY_SHIFT) + FOUR_YEARS - 1) / FOUR_YEARS;

   // days before March-based month mo, i.e. (mo*153+2)/5
   function automatic logic [8:0] month_start(input logic [3:0] mo);
      logic [8:0] r;
      case (mo)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // length of calendar month 1..12
   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] r;
      case (month)
         4'd2:                     r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
         default:                  r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/gregorian_day_number_converter.sv -----
// Six-stage pipeline; the result is presented from the stage 6 result register.
// Throughput one beat per cycle while rsp_ready is high; no path in a stage
// crosses more than one constant multiply, so the stage count sets the latency.
// req_ready drops only when all six stages are full and rsp_ready is low.
// Synchronous reset empties the pipeline; data registers are not reset.
// Depends on gdnc_pkg and gregorian_day_number_converter_defines.svh.
`timescale 1ns / 1ps
`include "gregorian_day_number_converter_defines.svh"

module gregorian_day_number_converter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic signed [gdnc_pkg::YEAR_W-1:0]    req_year_in,
   input  logic [gdnc_pkg::MONTH_IN_W-1:0]       req_month_in,
   input  logic [gdnc_pkg::DAY_IN_W-1:0]         req_day_in,
   input  logic [gdnc_pkg::SDN_W-1:0]            req_day_number_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid_res,
   output logic [gdnc_pkg::SDN_W-1:0]            rsp_day_number_out,
   output logic signed [gdnc_pkg::YEAR_W-1:0]    rsp_year_out,
   output logic [gdnc_pkg::MONTH_OUT_W-1:0]      rsp_month_out,
   output logic [gdnc_pkg::DAY_OUT_W-1:0]        rsp_day_out
);

   typedef struct packed {
      logic              act;
      logic signed [15:0] year;
      logic [5:0]        month;
      logic [5:0]        day;
      logic [22:0]       sdn;
   } s1_type;

   typedef struct packed {
      logic        act;
      logic        ok;
      logic [15:0] yr;
      logic [15:0] yr0;
      logic [8:0]  q_yr;
      logic [8:0]  q_yr0;
      logic [3:0]  mo;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        nz;
      logic [25:0] t;
      logic [7:0]  cent;
   } s2_type;

   typedef struct packed {
      logic        act;
      logic        ok;
      logic [6:0]  ya;
      logic [24:0] ctm;
      logic        leap;
      logic [3:0]  mo;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        nz;
      logic [17:0] t2;
      logic [14:0] cent100;
   } s3_type;

   typedef struct packed {
      logic        act;
      logic        day_ok;
      logic [24:0] part;
      logic [15:0] yt;
      logic        nz;
      logic [17:0] t2;
      logic [14:0] cent100;
      logic [6:0]  yq;
   } s4_type;

   typedef struct packed {
      logic              act;
      logic              a_valid;
      logic [22:0]       sdn;
      logic              nz;
      logic [8:0]        off;
      logic signed [15:0] ybase;
   } s5_type;

   typedef struct packed {
      logic              valid_res;
      logic [22:0]       dn;
      logic signed [15:0] year;
      logic [3:0]        month;
      logic [4:0]        day;
   } out_type;

   logic [5:0] full_ff, full_in;
   logic [5:0] adv;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   out_type out_ff, out_in;

   // ---------------- flow control ----------------
   always_comb begin
      adv[5] = !full_ff[5] || rsp_ready;
      for (int k = 4; k >= 0; k--) begin
         adv[k] = !full_ff[k] || adv[k+1];
      end
      full_in[0] = adv[0] ? req_valid : full_ff[0];
      for (int k = 1; k < 6; k++) begin
         full_in[k] = adv[k] ? full_ff[k-1] : full_ff[k];
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = full_ff[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '0;
      end else begin
         full_ff <= full_in;
      end
   end

   // ---------------- stage 1: input register ----------------
   always_comb begin
      s1_in.act   = req_action;
      s1_in.year  = req_year_in;
      s1_in.month = req_month_in;
      s1_in.day   = req_day_in;
      s1_in.sdn   = req_day_number_in;
   end

   // ---------------- stage 2: range checks, divide by 100 and by 146097 ----------------
   logic [32:0] s2_prod_yr, s2_prod_yr0;
   logic [52:0] s2_prod_t;
   logic        s2_year_ok, s2_month_ok, s2_day_ok, s2_too_early;

   always_comb begin
      s2_year_ok  = (s1_ff.year != '0) && (s1_ff.year >= gdnc_pkg::EARLIEST_YEAR);
      s2_month_ok = (s1_ff.month != '0) && (s1_ff.month <= 6'(gdnc_pkg::DECEMBER));
      s2_day_ok   = (s1_ff.day != '0) && (s1_ff.day <= 6'(gdnc_pkg::MAX_MDAY));
      s2_too_early = (s1_ff.year == gdnc_pkg::EARLIEST_YEAR) &&
                     ((s1_ff.month < 6'(gdnc_pkg::FIRST_MONTH_BC)) ||
                      ((s1_ff.month == 6'(gdnc_pkg::FIRST_MONTH_BC)) &&
                       (s1_ff.day < 6'(gdnc_pkg::FIRST_DAY_BC))));

      s2_in.act = s1_ff.act;
      s2_in.ok  = s2_year_ok && s2_month_ok && s2_day_ok && !s2_too_early;

      // no year zero: BC years shift one further
      s2_in.yr0 = s1_ff.year[15] ? 16'(s1_ff.year + 16'(gdnc_pkg::EPOCH_YEAR_BC))
                                 : 16'(s1_ff.year + 16'(gdnc_pkg::EPOCH_YEAR));
      if (s1_ff.month > 6'(gdnc_pkg::FEBRUARY)) begin
         s2_in.yr = s2_in.yr0;
         s2_in.mo = 4'(s1_ff.month - 6'(gdnc_pkg::MARCH));
      end else begin
         s2_in.yr = s2_in.yr0 - 16'd1;
         s2_in.mo = 4'(s1_ff.month + 6'(gdnc_pkg::MONTHS_TO_JAN));
      end

      s2_prod_yr  = 33'(s2_in.yr)  * 33'(gdnc_pkg::CENT_RECIP);
      s2_prod_yr0 = 33'(s2_in.yr0) * 33'(gdnc_pkg::CENT_RECIP);
      s2_in.q_yr  = s2_prod_yr[31:23];
      s2_in.q_yr0 = s2_prod_yr0[31:23];
      s2_in.month = s1_ff.month[3:0];
      s2_in.day   = s1_ff.day[4:0];

      s2_in.nz   = (s1_ff.sdn != '0);
      s2_in.t    = {1'b0, s1_ff.sdn, 2'b00} + 26'(gdnc_pkg::T_BIAS);
      s2_prod_t  = 53'(s2_in.t) * 53'(gdnc_pkg::FC_RECIP);
      s2_in.cent = s2_prod_t[51:44];
   end

   // ---------------- stage 3: remainders, century term, leap year ----------------
   logic [15:0] s3_r0;
   logic [25:0] s3_r1;
   logic [26:0] s3_ctm_full;

   always_comb begin
      s3_in.act   = s2_ff.act;
      s3_in.ok    = s2_ff.ok;
      s3_in.ya    = 7'(s2_ff.yr - 16'(s2_ff.q_yr * 16'(gdnc_pkg::CENTURY)));
      s3_ctm_full = 27'(s2_ff.q_yr) * 27'(gdnc_pkg::FOUR_CENTS);
      s3_in.ctm   = s3_ctm_full[26:2];
      s3_r0       = s2_ff.yr0 - 16'(s2_ff.q_yr0 * 16'(gdnc_pkg::CENTURY));
      s3_in.leap  = (s2_ff.yr0[1:0] == 2'd0) && ((s3_r0 != '0) || (s2_ff.q_yr0[1:0] == 2'd0));
      s3_in.mo    = s2_ff.mo;
      s3_in.month = s2_ff.month;
      s3_in.day   = s2_ff.day;

      s3_in.nz      = s2_ff.nz;
      s3_r1         = s2_ff.t - 26'(26'(s2_ff.cent) * 26'(gdnc_pkg::FOUR_CENTS));
      // (r/4)*4+3
      s3_in.t2      = {s3_r1[17:2], 2'b11};
      s3_in.cent100 = 15'(15'(s2_ff.cent) * 15'(gdnc_pkg::CENTURY));
   end

   // ---------------- stage 4: year-in-century term, month length, divide by 1461 ----------------
   logic [17:0] s4_yt_full;
   logic [36:0] s4_prod_t2;

   always_comb begin
      s4_in.act    = s3_ff.act;
      s4_in.day_ok = s3_ff.ok &&
                     (s3_ff.day <= gdnc_pkg::month_length(s3_ff.month, s3_ff.leap));
      s4_in.part   = s3_ff.ctm + 25'(gdnc_pkg::month_start(s3_ff.mo)) + 25'(s3_ff.day);
      s4_yt_full   = 18'(s3_ff.ya) * 18'(gdnc_pkg::FOUR_YEARS);
      s4_in.yt     = s4_yt_full[17:2];

      s4_in.nz      = s3_ff.nz;
      s4_in.t2      = s3_ff.t2;
      s4_in.cent100 = s3_ff.cent100;
      s4_prod_t2    = 37'(s3_ff.t2) * 37'(gdnc_pkg::FY_RECIP);
      s4_in.yq      = s4_prod_t2[35:29];
   end

   // ---------------- stage 5: day number sum, day of year ----------------
   logic [24:0] s5_sdn_w;
   logic [17:0] s5_r2;

   always_comb begin
      s5_in.act     = s4_ff.act;
      s5_sdn_w      = s4_ff.part + 25'(s4_ff.yt) - 25'(gdnc_pkg::OFFSET_DAYS);
      s5_in.a_valid = s4_ff.day_ok && (s5_sdn_w <= 25'(gdnc_pkg::MAX_DAYNUM));
      s5_in.sdn     = s5_sdn_w[22:0];

      s5_in.nz    = s4_ff.nz;
      s5_r2       = s4_ff.t2 - 18'(18'(s4_ff.yq) * 18'(gdnc_pkg::FOUR_YEARS));
      s5_in.off   = s5_r2[10:2];
      s5_in.ybase = 16'(16'(s4_ff.cent100) + 16'(s4_ff.yq) - 16'(gdnc_pkg::EPOCH_YEAR));
   end

   // ---------------- stage 6: month search, year fix-up, result register ----------------
   logic [3:0]         s6_mo;
   logic [8:0]         s6_dy;
   logic signed [15:0] s6_year;

   always_comb begin
      s6_mo = '0;
      for (int k = 1; k < 12; k++) begin
         if (s5_ff.off >= gdnc_pkg::month_start(4'(k))) begin
            s6_mo = 4'(k);
         end
      end
      s6_dy   = s5_ff.off - gdnc_pkg::month_start(s6_mo) + 9'd1;
      s6_year = s5_ff.ybase;
      if (s6_mo >= 4'(gdnc_pkg::FIRST_NEXT_YR)) begin
         s6_year = s6_year + 16'sd1;
      end
      // no year zero
      if (s6_year <= 16'sd0) begin
         s6_year = s6_year - 16'sd1;
      end

      out_in = '0;
      if (!s5_ff.act) begin
         out_in.valid_res = s5_ff.a_valid;
         out_in.dn        = s5_ff.a_valid ? s5_ff.sdn : '0;
      end else if (s5_ff.nz) begin
         out_in.valid_res = 1'b1;
         out_in.year      = s6_year;
         out_in.month     = (s6_mo < 4'(gdnc_pkg::FIRST_NEXT_YR))
                            ? s6_mo + 4'(gdnc_pkg::MARCH)
                            : s6_mo - 4'(gdnc_pkg::MONTHS_TO_JAN);
         out_in.day       = s6_dy[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) s1_ff  <= s1_in;
      if (adv[1]) s2_ff  <= s2_in;
      if (adv[2]) s3_ff  <= s3_in;
      if (adv[3]) s4_ff  <= s4_in;
      if (adv[4]) s5_ff  <= s5_in;
      if (adv[5]) out_ff <= out_in;
   end

   assign rsp_valid_res      = out_ff.valid_res;
   assign rsp_day_number_out = out_ff.dn;
   assign rsp_year_out       = out_ff.year;
   assign rsp_month_out      = out_ff.month;
   assign rsp_day_out        = out_ff.day;

   // ---------------- assertions ----------------
   `GDNC_ASSERT_SAME(a_dn_only, clock, reset, rsp_valid && (rsp_day_number_out != '0),
      rsp_valid_res && (rsp_year_out == '0) && (rsp_month_out == '0) && (rsp_day_out == '0))
   `GDNC_ASSERT_SAME(a_date_only, clock, reset, rsp_valid && (rsp_month_out != '0),
      rsp_valid_res && (rsp_month_out <= 4'd12) && (rsp_day_out != '0) &&
      (rsp_day_number_out == '0))
   `GDNC_ASSERT_SAME(a_full_stall, clock, reset, (&full_ff) && !rsp_ready, !req_ready)
   `GDNC_ASSERT_NEXT(a_accept_fill, clock, reset, req_valid && req_ready, full_ff[0])

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for gregorian_day_number_converter: date and day number
// beats are predicted in the bench and compared field by field as they return.
// Depends on gdnc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb;
   import gdnc_pkg::*;

   localparam logic ACT_TO_DAY_NUMBER = 1'b0;
   localparam logic ACT_TO_DATE       = 1'b1;
   localparam int   CYCLE_LIMIT       = 200_000;
   localparam int   MAX_GAP           = 15;
   localparam int   LATENCY_SLACK     = 20;
   localparam int   HOLD_CYCLES       = 80;

   typedef struct packed {
      logic                          valid_res;
      logic [SDN_W-1:0]              day_number;
      logic signed [YEAR_W-1:0]      year;
      logic [MONTH_OUT_W-1:0]        month;
      logic [DAY_OUT_W-1:0]          day;
   } calendar_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_action = 1'b0;
   logic signed [YEAR_W-1:0]      req_year_in = '0;
   logic [MONTH_IN_W-1:0]         req_month_in = '0;
   logic [DAY_IN_W-1:0]           req_day_in = '0;
   logic [SDN_W-1:0]              req_day_number_in = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_valid_res;
   logic [SDN_W-1:0]              rsp_day_number_out;
   logic signed [YEAR_W-1:0]      rsp_year_out;
   logic [MONTH_OUT_W-1:0]        rsp_month_out;
   logic [DAY_OUT_W-1:0]          rsp_day_out;

   calendar_result_type pending_results[$];
   int unsigned      cycle_count = 0;
   int               error_count = 0;
   bit               tx_quiet = 1'b0;
   bit               rx_quiet = 1'b0;
   int               hold_requests = 0;   // raised by the tests
   int               hold_served = 0;     // followed by the receiver
   int               hold_left = 0;
   int               stall_left = 0;

   gregorian_day_number_converter DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_year_in        (req_year_in),
      .req_month_in       (req_month_in),
      .req_day_in         (req_day_in),
      .req_day_number_in  (req_day_number_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_valid_res      (rsp_valid_res),
      .rsp_day_number_out (rsp_day_number_out),
      .rsp_year_out       (rsp_year_out),
      .rsp_month_out      (rsp_month_out),
      .rsp_day_out        (rsp_day_out)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // day number to proleptic Gregorian date, no year zero
   function automatic void serial_to_civil(input longint sdn, output longint y,
                                           output longint m, output longint d);
      longint t, cent, yr, doy, mo, dy;
      if (sdn <= 0) begin
         y = 0;
         m = 0;
         d = 0;
      end else begin
         t    = (sdn + OFFSET_DAYS) * 4 - 1;
         cent = t / FOUR_CENTS;
         t    = ((t % FOUR_CENTS) / 4) * 4 + 3;
         yr   = cent * CENTURY + t / FOUR_YEARS;
         doy  = (t % FOUR_YEARS) / 4 + 1;
         t    = doy * 5 - 3;
         mo   = t / FIVE_MONTHS;
         dy   = (t % FIVE_MONTHS) / 5 + 1;
         if (mo < FIRST_NEXT_YR) begin
            mo = mo + MARCH;
         end else begin
            yr = yr + 1;
            mo = mo - MONTHS_TO_JAN;
         end
         yr = yr - EPOCH_YEAR;
         if (yr <= 0) yr = yr - 1;
         y = yr;
         m = mo;
         d = dy;
      end
   endfunction

   function automatic calendar_result_type predict_conversion(
         input logic action, input logic signed [YEAR_W-1:0] y_in,
         input logic [MONTH_IN_W-1:0] m_in, input logic [DAY_IN_W-1:0] d_in,
         input logic [SDN_W-1:0] sdn_in);
      calendar_result_type r;
      longint yy, mm, dd, yr, mo, sdn, ry, rm, rd;
      r  = '0;
      yy = longint'(y_in);
      mm = longint'(m_in);
      dd = longint'(d_in);
      if (action == ACT_TO_DAY_NUMBER) begin
         sdn = 0;
         if (!(yy == 0 || yy < -FIRST_YEAR || mm < 1 || mm > DECEMBER ||
               dd < 1 || dd > MAX_MDAY ||
               (yy == -FIRST_YEAR && (mm < FIRST_MONTH_BC ||
                                      (mm == FIRST_MONTH_BC && dd < FIRST_DAY_BC))))) begin
            yr = (yy < 0) ? yy + EPOCH_YEAR_BC : yy + EPOCH_YEAR;
            if (mm > FEBRUARY) begin
               mo = mm - MARCH;
            end else begin
               mo = mm + MONTHS_TO_JAN;
               yr = yr - 1;
            end
            sdn = ((yr / CENTURY) * FOUR_CENTS) / 4 + ((yr % CENTURY) * FOUR_YEARS) / 4
                + (mo * FIVE_MONTHS + 2) / 5 + dd - OFFSET_DAYS;
         end
         // accept only an exact round trip that fits the output width
         serial_to_civil(sdn, ry, rm, rd);
         if (sdn > 0 && sdn <= MAX_DAYNUM && ry == yy && rm == mm && rd == dd) begin
            r.valid_res  = 1'b1;
            r.day_number = sdn[SDN_W-1:0];
         end
      end else if (sdn_in != 0) begin
         sdn = longint'(sdn_in);
         serial_to_civil(sdn, ry, rm, rd);
         r.valid_res = 1'b1;
         r.year      = ry[YEAR_W-1:0];
         r.month     = rm[MONTH_OUT_W-1:0];
         r.day       = rd[DAY_OUT_W-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // result side: per-beat stall, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left   = HOLD_CYCLES;
         hold_served = hold_requests;
      end
      if (rsp_valid === 1'b1 && rsp_ready)
         stall_left = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      calendar_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing pending", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_valid_res !== want.valid_res)
               report_mismatch("valid_res", rsp_valid_res, want.valid_res);
            if (rsp_day_number_out !== want.day_number)
               report_mismatch("day_number_out", rsp_day_number_out, want.day_number);
            if (rsp_year_out !== want.year)
               report_mismatch("year_out", $signed(rsp_year_out), $signed(want.year));
            if (rsp_month_out !== want.month)
               report_mismatch("month_out", rsp_month_out, want.month);
            if (rsp_day_out !== want.day)
               report_mismatch("day_out", rsp_day_out, want.day);
         end
      end
   end

   // valid is left high on return so a zero gap keeps it asserted
   task automatic send_beat(input logic action, input logic signed [YEAR_W-1:0] y,
                            input logic [MONTH_IN_W-1:0] m, input logic [DAY_IN_W-1:0] d,
                            input logic [SDN_W-1:0] sdn);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= action;
      req_year_in       <= y;
      req_month_in      <= m;
      req_day_in        <= d;
      req_day_number_in <= sdn;
      pending_results.push_back(predict_conversion(action, y, m, d, sdn));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_date(input int y, input int m, input int d);
      send_beat(ACT_TO_DAY_NUMBER, YEAR_W'(y), MONTH_IN_W'(m), DAY_IN_W'(d),
                SDN_W'($urandom));
   endtask

   task automatic send_day_number(input int sdn);
      send_beat(ACT_TO_DATE, YEAR_W'($urandom), MONTH_IN_W'($urandom), DAY_IN_W'($urandom),
                SDN_W'(sdn));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic send_random_date();
      longint ry, rm, rd;
      case ($urandom_range(0, 4))
         0: begin
            serial_to_civil(longint'($urandom_range(1, MAX_DAYNUM)), ry, rm, rd);
            send_date(int'(ry), int'(rm), int'(rd));
         end
         1: send_date(int'($urandom_range(0, 4)) - FIRST_YEAR - 1, $urandom_range(1, 12),
                      $urandom_range(1, MAX_MDAY));
         2: send_date(int'($urandom_range(0, 22968)) - FIRST_YEAR, $urandom_range(1, 12),
                      $urandom_range(28, MAX_MDAY));
         default: send_date(int'($urandom_range(0, 22968)) - FIRST_YEAR,
                            $urandom_range(1, 12), $urandom_range(1, MAX_MDAY));
      endcase
   endtask

   task automatic send_random_day_number();
      case ($urandom_range(0, 9))
         0:       send_day_number(0);
         1:       send_day_number($urandom_range(1, 4000));
         2:       send_day_number(MAX_DAYNUM - int'($urandom_range(0, 400)));
         default: send_day_number($urandom_range(1, MAX_DAYNUM));
      endcase
   endtask

   task automatic test_directed_dates();
      longint ry, rm, rd;
      send_date(2000, 1, 1);
      send_date(-FIRST_YEAR, FIRST_MONTH_BC, FIRST_DAY_BC);     // day number 1
      send_date(-FIRST_YEAR, FIRST_MONTH_BC, FIRST_DAY_BC - 1);
      send_date(-FIRST_YEAR, 10, 31);
      send_date(-FIRST_YEAR - 1, 12, 31);
      send_date(0, 6, 15);                                      // no year zero
      send_date(-32768, 1, 1);
      send_date(32767, 12, 31);                                 // too wide for output
      send_date(2000, 0, 1);
      send_date(2000, 13, 1);
      send_date(2000, 63, 63);
      send_date(2000, 1, 0);
      send_date(2000, 1, 32);
      send_date(2000, 2, 29);
      send_date(1900, 2, 29);
      send_date(2001, 2, 31);
      send_date(2000, 4, 31);
      send_date(-1, 12, 31);
      send_date(1, 1, 1);
      serial_to_civil(MAX_DAYNUM, ry, rm, rd);
      send_date(int'(ry), int'(rm), int'(rd));
      serial_to_civil(longint'(MAX_DAYNUM) + 1, ry, rm, rd);
      send_date(int'(ry), int'(rm), int'(rd));
   endtask

   task automatic test_directed_day_numbers();
      send_day_number(0);
      send_day_number(1);
      send_day_number(1721425);
      send_day_number(1721426);
      send_day_number(2451545);
      send_day_number(MAX_DAYNUM);
   endtask

   task automatic test_random_dates();
      repeat (250) send_random_date();
   endtask

   task automatic test_random_day_numbers();
      repeat (200) send_random_day_number();
   endtask

   task automatic test_random_noise();
      repeat (100) send_beat(1'($urandom_range(0, 1)), YEAR_W'($urandom),
                             MONTH_IN_W'($urandom), DAY_IN_W'($urandom), SDN_W'($urandom));
   endtask

   task automatic test_back_to_back();
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      repeat (40) begin
         if ($urandom_range(0, 1)) send_random_date();
         else send_random_day_number();
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   // output held off long enough for the pipeline to fill and stall the input
   task automatic test_output_hold_off();
      hold_requests++;
      tx_quiet     = 1'b1;
      repeat (30) send_random_date();
      tx_quiet     = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_dates();
      test_directed_day_numbers();
      wait_for_drain();
      test_random_dates();
      test_output_hold_off();
      wait_for_drain();
      test_random_day_numbers();
      test_back_to_back();
      test_random_noise();
      wait_for_drain();
      repeat (LATENCY_SLACK) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
